/* sv/cpd_pkg.sv */
// cpd_pkg: shared types and constants for the pairwise-deletion covariance block
// used by cpd_div.sv and covariance_pairwise_deletion.sv, no dependencies
package cpd_pkg;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 16;

   localparam int CFG_ROW_W  = 11;
   localparam int CFG_COL_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int SAMPLE_W   = 16;
   localparam int RIDX_W     = 4;
   localparam int COV_W      = 48;
   localparam int PAIR_OUT_W = 11;
   localparam int MEAN_W     = 32;
   localparam int DEV_W      = 26;
   localparam int PROD_W     = 2 * DEV_W;

   localparam logic [CFG_ROW_W-1:0] ROW_COUNT_RESET = 11'd1024;
   localparam logic [CFG_COL_W-1:0] COL_COUNT_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } cpd_div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_M_RD,
      ST_M_ACC,
      ST_M_DIV,
      ST_M_WAIT,
      ST_M_WR,
      ST_P_K,
      ST_P_J,
      ST_P_J2,
      ST_C_RDA,
      ST_C_RDB,
      ST_C_MUL,
      ST_C_ACC,
      ST_C_DIV,
      ST_C_WAIT,
      ST_C_WR1,
      ST_C_WR2
   } cpd_state_type;

endpackage

/* sv/cpd_div.sv */
// cpd_div: restoring divider, one quotient bit per cycle
// depends on cpd_pkg
module cpd_div #(
   parameter int W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [W-1:0]             num,
   input  logic [W-1:0]             den,
   output cpd_pkg::cpd_div_stat_type stat,
   output logic [W-1:0]             quot
);
   import cpd_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    rem_sh;
   logic          fits;

   assign rem_sh = {rem_ff[W-1:0], quo_ff[W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quo_ff;

endmodule

/* sv/covariance_pairwise_deletion.sv */
// covariance_pairwise_deletion: covariance matrix with pairwise deletion of missing values
// depends on cpd_pkg and cpd_div
// the last load word starts the compute pass: the means of all columns, then the
//   covariance of every pair, each a serial pass over the rows, paced by the single
//   data memory port and the divider
// a read word is answered via the read state and the response register; one word at a time
// reset (synchronous, active high) clears control state; result stores need no clearing
module covariance_pairwise_deletion #(
   parameter int MAX_ROWS = cpd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = cpd_pkg::DEF_MAX_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [cpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cpd_pkg::CFG_ROW_W-1:0]        csr_wdata,
   // request words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [cpd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_sample_good,
   input  logic [cpd_pkg::RIDX_W-1:0]           req_read_row,
   input  logic [cpd_pkg::RIDX_W-1:0]           req_read_col,
   // response words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cpd_pkg::COV_W-1:0]     rsp_cov_value,
   output logic [cpd_pkg::PAIR_OUT_W-1:0]       rsp_pair_count,
   output logic                                 rsp_value_valid
);
   import cpd_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PC_W   = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
   localparam int SUM_W  = SAMPLE_W + ROW_W;
   localparam int ACC_W  = PROD_W + ROW_W;
   localparam int DW     = ACC_W + 2;
   localparam int CA_W   = 2 * COL_W;
   localparam int CE_W   = COV_W + ROW_W;
   localparam logic [DW-1:0] SAT_MAG = DW'(48'h7FFF_FFFF_FFFF);

   // configuration and control
   logic [CFG_ROW_W-1:0] row_count_ff, row_count_in;
   logic [CFG_COL_W-1:0] col_count_ff, col_count_in;
   logic                 result_ready_ff, result_ready_in;
   cpd_state_type        state_ff, state_in;

   // load position
   logic [ROW_W-1:0]  load_row_ff, load_row_in;
   logic [COL_W-1:0]  load_col_ff, load_col_in;
   logic [ADDR_W-1:0] load_addr_ff, load_addr_in;

   // compute iterators and datapath
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [ADDR_W-1:0]        base_ff, base_in;
   logic [COL_W-1:0]         j_ff, j_in, k_ff, k_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [ROW_W-1:0]         cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ROW_W-1:0]         pairs_ff, pairs_in;
   logic [SAMPLE_W:0]        a_ff, a_in;
   logic signed [MEAN_W-1:0] mean_k_ff, mean_k_in, mean_j_ff, mean_j_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     both_ff, both_in;
   logic                     neg_ff, neg_in;
   logic signed [COV_W-1:0]  val_ff, val_in;
   logic                     rd_ok_ff, rd_ok_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COV_W-1:0]  rsp_cov_ff, rsp_cov_in;
   logic [PAIR_OUT_W-1:0]    rsp_pair_ff, rsp_pair_in;
   logic                     rsp_vv_ff, rsp_vv_in;

   // memories
   logic [SAMPLE_W:0]        data_mem [MAX_ROWS*MAX_COLS];
   logic [SAMPLE_W:0]        data_rd_ff;
   logic [MEAN_W-1:0]        mean_mem [MAX_COLS];
   logic signed [MEAN_W-1:0] mean_rd_ff;
   logic [CE_W-1:0]          cov_mem [2**CA_W];
   logic [CE_W-1:0]          cov_rd_ff;

   // decoded control
   logic              req_take, load_take, read_take, load_last;
   logic              data_we, mean_we, cov_we, div_start;
   logic [ADDR_W-1:0] data_raddr;
   logic [COL_W-1:0]  mean_raddr;
   logic [CA_W-1:0]   cov_waddr, cov_raddr;
   logic [ROW_W-1:0]  n_eff;
   logic [PC_W-1:0]   p_eff;
   logic              row_last, j_last;
   logic [COL_W-1:0]  rr_idx, rc_idx;

   // divider
   logic [DW-1:0]     div_num, div_den, div_quot;
   cpd_div_stat_type  div_stat;
   logic [SUM_W-1:0]  sum_mag;
   logic [ACC_W-1:0]  acc_mag;
   logic [DW-1:0]     cov_den0;
   logic [COV_W:0]    q_sat;
   logic signed [COV_W-1:0] q_val;

   // deviations of the two samples of a row
   logic signed [MEAN_W:0]  da_full, db_full;
   logic signed [DEV_W-1:0] da, db;

   // effective sizes, out-of-range registers are clamped
   always_comb begin
      if (row_count_ff == '0)
         n_eff = ROW_W'(1);
      else if (32'(row_count_ff) > MAX_ROWS)
         n_eff = ROW_W'(MAX_ROWS);
      else
         n_eff = ROW_W'(row_count_ff);
      if (col_count_ff == '0)
         p_eff = PC_W'(1);
      else if (32'(col_count_ff) > MAX_COLS)
         p_eff = PC_W'(MAX_COLS);
      else
         p_eff = PC_W'(col_count_ff);
   end

   assign row_last  = row_ff == n_eff - ROW_W'(1);
   assign j_last    = PC_W'(j_ff) == p_eff - PC_W'(1);
   assign load_last = (load_row_ff == n_eff - ROW_W'(1))
                   && (PC_W'(load_col_ff) == p_eff - PC_W'(1));

   assign req_take  = req_valid && !req_stall;
   assign load_take = req_take && (req_type == REQ_LOAD);
   assign read_take = req_take && (req_type == REQ_READ);

   assign rr_idx    = COL_W'(req_read_row);
   assign rc_idx    = COL_W'(req_read_col);
   assign cov_raddr = {rr_idx, rc_idx};

   // rounding divide: (2*mag + den) / (2*den)
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign cov_den0 = DW'(pairs_ff - ROW_W'(1)) << 16;

   always_comb begin
      if (state_ff == ST_M_DIV) begin
         div_num = (DW'(sum_mag) << 9) + DW'(cnt_ff);
         div_den = DW'(cnt_ff) << 1;
      end else begin
         div_num = (DW'(acc_mag) << 1) + cov_den0;
         div_den = cov_den0 << 1;
      end
   end

   // saturate magnitude, then restore sign
   assign q_sat = (div_quot > SAT_MAG) ? (COV_W+1)'(SAT_MAG) + (COV_W+1)'(neg_ff)
                                       : (COV_W+1)'(div_quot);
   assign q_val = neg_ff ? -$signed(q_sat[COV_W-1:0]) : $signed(q_sat[COV_W-1:0]);

   // deviation = sample*256 - mean, fits DEV_W bits
   assign da_full = $signed({{(MEAN_W-SAMPLE_W-7){a_ff[SAMPLE_W-1]}}, a_ff[SAMPLE_W-1:0], 8'b0})
                  - $signed({mean_k_ff[MEAN_W-1], mean_k_ff});
   assign db_full = $signed({{(MEAN_W-SAMPLE_W-7){data_rd_ff[SAMPLE_W-1]}},
                             data_rd_ff[SAMPLE_W-1:0], 8'b0})
                  - $signed({mean_j_ff[MEAN_W-1], mean_j_ff});
   assign da = da_full[DEV_W-1:0];
   assign db = db_full[DEV_W-1:0];

   cpd_div #(
      .W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (read_take)
               state_in = ST_READ;
            else if (load_take && load_last)
               state_in = ST_M_RD;
         end
         ST_READ:   state_in = ST_IDLE;
         ST_M_RD:   state_in = ST_M_ACC;
         ST_M_ACC:  state_in = row_last ? ST_M_DIV : ST_M_RD;
         ST_M_DIV:  state_in = (cnt_ff == '0) ? ST_M_WR : ST_M_WAIT;
         ST_M_WAIT: state_in = div_stat.done ? ST_M_WR : ST_M_WAIT;
         ST_M_WR:   state_in = j_last ? ST_P_K : ST_M_RD;
         ST_P_K:    state_in = ST_P_J;
         ST_P_J:    state_in = ST_P_J2;
         ST_P_J2:   state_in = ST_C_RDA;
         ST_C_RDA:  state_in = ST_C_RDB;
         ST_C_RDB:  state_in = ST_C_MUL;
         ST_C_MUL:  state_in = ST_C_ACC;
         ST_C_ACC:  state_in = row_last ? ST_C_DIV : ST_C_RDA;
         ST_C_DIV:  state_in = (pairs_ff < ROW_W'(2)) ? ST_C_WR1 : ST_C_WAIT;
         ST_C_WAIT: state_in = div_stat.done ? ST_C_WR1 : ST_C_WAIT;
         ST_C_WR1:  state_in = ST_C_WR2;
         ST_C_WR2: begin
            if (k_ff == j_ff && j_last)
               state_in = ST_IDLE;
            else
               state_in = ST_P_K;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs and memory ports
   always_comb begin
      req_stall  = (state_ff != ST_IDLE) || rsp_valid_ff;
      data_we    = load_take;
      mean_we    = state_ff == ST_M_WR;
      cov_we     = (state_ff == ST_C_WR1) || (state_ff == ST_C_WR2);
      div_start  = ((state_ff == ST_M_DIV) && (cnt_ff != '0))
                || ((state_ff == ST_C_DIV) && (pairs_ff >= ROW_W'(2)));
      data_raddr = (state_ff == ST_C_RDA) ? base_ff + ADDR_W'(k_ff)
                                          : base_ff + ADDR_W'(j_ff);
      mean_raddr = (state_ff == ST_P_K) ? k_ff : j_ff;
      cov_waddr  = (state_ff == ST_C_WR1) ? {j_ff, k_ff} : {k_ff, j_ff};
   end

   // datapath next values
   always_comb begin
      row_count_in    = row_count_ff;
      col_count_in    = col_count_ff;
      result_ready_in = result_ready_ff;
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      load_addr_in    = load_addr_ff;
      row_in          = row_ff;
      base_in         = base_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      acc_in          = acc_ff;
      pairs_in        = pairs_ff;
      a_in            = a_ff;
      mean_k_in       = mean_k_ff;
      mean_j_in       = mean_j_ff;
      prod_in         = prod_ff;
      both_in         = both_ff;
      neg_in          = neg_ff;
      val_in          = val_ff;
      rd_ok_in        = rd_ok_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_cov_in      = rsp_cov_ff;
      rsp_pair_in     = rsp_pair_ff;
      rsp_vv_in       = rsp_vv_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata[CFG_COL_W-1:0];
            default: ;
         endcase
         load_row_in     = '0;
         load_col_in     = '0;
         load_addr_in    = '0;
         result_ready_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (read_take)
               rd_ok_in = result_ready_ff && (PC_W'(rr_idx) < p_eff)
                       && (PC_W'(rc_idx) < p_eff) && (RIDX_W'(rr_idx) == req_read_row)
                       && (RIDX_W'(rc_idx) == req_read_col);
            if (load_take) begin
               // first word of a new matrix drops the old result
               if (load_addr_ff == '0)
                  result_ready_in = 1'b0;
               if (load_last) begin
                  load_row_in  = '0;
                  load_col_in  = '0;
                  load_addr_in = '0;
                  row_in       = '0;
                  base_in      = '0;
                  j_in         = '0;
                  sum_in       = '0;
                  cnt_in       = '0;
               end else begin
                  load_addr_in = load_addr_ff + ADDR_W'(1);
                  if (PC_W'(load_col_ff) == p_eff - PC_W'(1)) begin
                     load_col_in = '0;
                     load_row_in = load_row_ff + ROW_W'(1);
                  end else begin
                     load_col_in = load_col_ff + COL_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cov_in   = rd_ok_ff ? $signed(cov_rd_ff[CE_W-1:ROW_W]) : '0;
            rsp_pair_in  = rd_ok_ff ? PAIR_OUT_W'(cov_rd_ff[ROW_W-1:0]) : '0;
            rsp_vv_in    = rd_ok_ff && (cov_rd_ff[ROW_W-1:0] >= ROW_W'(2));
         end
         ST_M_ACC: begin
            if (data_rd_ff[SAMPLE_W]) begin
               sum_in = sum_ff + SUM_W'($signed(data_rd_ff[SAMPLE_W-1:0]));
               cnt_in = cnt_ff + ROW_W'(1);
            end
            base_in = base_ff + ADDR_W'(p_eff);
            row_in  = row_ff + ROW_W'(1);
         end
         ST_M_DIV: begin
            neg_in = sum_ff[SUM_W-1];
            val_in = '0;
         end
         ST_M_WAIT: begin
            if (div_stat.done)
               val_in = q_val;
         end
         ST_M_WR: begin
            row_in  = '0;
            base_in = '0;
            sum_in  = '0;
            cnt_in  = '0;
            if (j_last) begin
               j_in = '0;
               k_in = '0;
            end else begin
               j_in = j_ff + COL_W'(1);
            end
         end
         ST_P_K: begin
            row_in   = '0;
            base_in  = '0;
            acc_in   = '0;
            pairs_in = '0;
         end
         ST_P_J:  mean_k_in = mean_rd_ff;
         ST_P_J2: mean_j_in = mean_rd_ff;
         ST_C_RDB: a_in = data_rd_ff;
         ST_C_MUL: begin
            prod_in = da * db;
            both_in = a_ff[SAMPLE_W] && data_rd_ff[SAMPLE_W];
         end
         ST_C_ACC: begin
            if (both_ff) begin
               acc_in   = acc_ff + ACC_W'(prod_ff);
               pairs_in = pairs_ff + ROW_W'(1);
            end
            base_in = base_ff + ADDR_W'(p_eff);
            row_in  = row_ff + ROW_W'(1);
         end
         ST_C_DIV: begin
            neg_in = acc_ff[ACC_W-1];
            val_in = '0;
         end
         ST_C_WAIT: begin
            if (div_stat.done)
               val_in = q_val;
         end
         ST_C_WR2: begin
            if (k_ff == j_ff) begin
               if (j_last)
                  result_ready_in = 1'b1;
               else begin
                  j_in = j_ff + COL_W'(1);
                  k_in = '0;
               end
            end else begin
               k_in = k_ff + COL_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_count_ff    <= ROW_COUNT_RESET;
         col_count_ff    <= COL_COUNT_RESET;
         result_ready_ff <= 1'b0;
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         load_addr_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         col_count_ff    <= col_count_in;
         result_ready_ff <= result_ready_in;
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         load_addr_ff    <= load_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      row_ff      <= row_in;
      base_ff     <= base_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      pairs_ff    <= pairs_in;
      a_ff        <= a_in;
      mean_k_ff   <= mean_k_in;
      mean_j_ff   <= mean_j_in;
      prod_ff     <= prod_in;
      both_ff     <= both_in;
      neg_ff      <= neg_in;
      val_ff      <= val_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_pair_ff <= rsp_pair_in;
      rsp_vv_ff   <= rsp_vv_in;
   end

   // sample store: {good, value}, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (data_we)
         data_mem[load_addr_ff] <= {req_sample_good, req_sample};
      data_rd_ff <= data_mem[data_raddr];
   end

   // column means
   always_ff @(posedge clock) begin
      if (mean_we)
         mean_mem[j_ff] <= val_ff[MEAN_W-1:0];
      mean_rd_ff <= $signed(mean_mem[mean_raddr]);
   end

   // covariance and pair count, both halves of the symmetric matrix
   always_ff @(posedge clock) begin
      if (cov_we)
         cov_mem[cov_waddr] <= {val_ff, pairs_ff};
      cov_rd_ff <= cov_mem[cov_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cov_value   = rsp_cov_ff;
   assign rsp_pair_count  = rsp_pair_ff;
   assign rsp_value_valid = rsp_vv_ff;

   // an entry flagged invalid always carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_vv_ff |-> rsp_cov_ff == '0)
      else $error("invalid entry with nonzero value");

   // the divider is never restarted while busy
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // a taken read word is answered from the read state
   assert property (@(posedge clock) disable iff (reset)
      read_take |=> state_ff == ST_READ)
      else $error("read word not answered");

   // the last pair written marks the result ready
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_WR2) && (k_ff == j_ff) && j_last && !csr_we |=> result_ready_ff)
      else $error("result not marked ready");

endmodule
